// File: rtl/core/kwlex_pkg.sv
// Package for the keyword lexer: token kinds, scan modes, keyword table.
// No dependencies.
package kwlex_pkg;

   localparam int KW_COUNT   = 53;
   localparam int KW_MAX_TBL = 9;

   localparam logic [6:0] K_END      = 7'd0;
   localparam logic [6:0] K_NEWLINE  = 7'd1;
   localparam logic [6:0] K_IDENT    = 7'd2;
   localparam logic [6:0] K_NUMBER   = 7'd3;
   localparam logic [6:0] K_STRING   = 7'd4;
   localparam logic [6:0] K_HOLE     = 7'd5;
   localparam logic [6:0] K_UNKNOWN  = 7'd6;
   localparam logic [6:0] K_PUNCT0   = 7'd7;
   localparam logic [6:0] K_KEYWORD0 = 7'd15;

   localparam logic [2:0] M_IDLE    = 3'd0;
   localparam logic [2:0] M_COMMENT = 3'd1;
   localparam logic [2:0] M_IDENT   = 3'd2;
   localparam logic [2:0] M_NUMBER  = 3'd3;
   localparam logic [2:0] M_STRING  = 3'd4;
   localparam logic [2:0] M_Q1      = 3'd5;
   localparam logic [2:0] M_Q2      = 3'd6;

   typedef logic [8*KW_MAX_TBL-1:0] kw_text_type;

   // keyword text, first character in the low byte, zero padded
   function automatic kw_text_type kw_text(input int idx);
      kw_text_type t;
      string s;
      t = '0;
      unique case (idx)
         0: s = "intent";   1: s = "let";      2: s = "be";       3: s = "set";
         4: s = "print";    5: s = "skip";     6: s = "read";     7: s = "repeat";
         8: s = "while";    9: s = "for";      10: s = "each";    11: s = "in";
         12: s = "pipe";    13: s = "match";   14: s = "when";    15: s = "catch";
         16: s = "error";   17: s = "yield";   18: s = "start";   19: s = "with";
         20: s = "map";     21: s = "filter";  22: s = "transform"; 23: s = "end";
         24: s = "if";      25: s = "then";    26: s = "elif";    27: s = "else";
         28: s = "define";  29: s = "taking";  30: s = "return";  31: s = "call";
         32: s = "passing"; 33: s = "list";    34: s = "at";      35: s = "put";
         36: s = "get";     37: s = "plus";    38: s = "minus";   39: s = "times";
         40: s = "divby";   41: s = "modulo";  42: s = "above";   43: s = "below";
         44: s = "atleast"; 45: s = "atmost";  46: s = "equals";  47: s = "and";
         48: s = "or";      49: s = "not";     50: s = "true";    51: s = "false";
         default: s = "value";
      endcase
      for (int i = 0; i < KW_MAX_TBL; i++) begin
         if (i < s.len()) t[8*i +: 8] = s[i];
      end
      return t;
   endfunction

   function automatic int kw_len(input int idx);
      kw_text_type t;
      int n;
      t = kw_text(idx);
      n = 0;
      for (int i = 0; i < KW_MAX_TBL; i++) begin
         if (t[8*i +: 8] != 8'd0) n = i + 1;
      end
      return n;
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

endpackage

// File: rtl/core/kwlex_match.sv
// Keyword compare: matches the buffered word against the keyword table in parallel.
// Depends on kwlex_pkg.
module kwlex_match #(
   parameter int KeywordMaxLen = 9,
   parameter int LenBits = 16
) (
   input  logic [8*KeywordMaxLen-1:0] word,
   input  logic [LenBits-1:0]         word_len,
   input  logic                       too_long,
   output logic [6:0]                 kind
);
   import kwlex_pkg::*;

   always_comb begin
      kind = K_IDENT;
      if (!too_long && word_len <= LenBits'(KeywordMaxLen)) begin
         for (int k = 0; k < KW_COUNT; k++) begin
            if (word_len == LenBits'(kw_len(k))
                && word[8*KW_MAX_TBL-1:0] == kw_text(k)) begin
               kind = K_KEYWORD0 + 7'(k);
            end
         end
      end
   end
endmodule

// File: rtl/core/kwlex_scan.sv
// Scanner: mode, position and word state, and up to three tokens per byte.
// Depends on kwlex_pkg and kwlex_match.
module kwlex_scan #(
   parameter int KeywordMaxLen = 9,
   parameter int PositionBits = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              source_byte,
   input  logic                    byte_present,
   input  logic                    end_of_source,
   output logic [1:0]              tok_count,
   output logic [3*7-1:0]          tok_kind,
   output logic [3*PositionBits-1:0] tok_line,
   output logic [3*PositionBits-1:0] tok_col,
   output logic [3*PositionBits-1:0] tok_len
);
   import kwlex_pkg::*;
   localparam int PB = PositionBits;
   localparam logic [PB-1:0] PosMax = '1;
   localparam logic [PB-1:0] One = PB'(1);
   // buffer holds the keyword length, zero padded to the table width
   localparam int BufLen = (KeywordMaxLen > KW_MAX_TBL) ? KeywordMaxLen : KW_MAX_TBL;

   logic [2:0]    mode_ff, mode_in;
   logic [PB-1:0] line_ff, line_in, col_ff, col_in;
   logic [PB-1:0] sline_ff, sline_in, scol_ff, scol_in, len_ff, len_in;
   logic          long_ff, long_in;
   logic [8*BufLen-1:0] word_ff, word_in, word_masked;
   logic [6:0]    word_kind;

   // a flushed identifier needs the keyword compare on the updated word
   logic [8*BufLen-1:0] fword;
   logic [6:0]          fkind;
   logic [PB-1:0]       flen;
   logic                flong;

   function automatic logic [PB-1:0] sat(input logic [PB-1:0] v);
      return (v == PosMax) ? v : v + One;
   endfunction

   // bytes past the word length are stale; mask them for the compare
   always_comb begin
      for (int i = 0; i < BufLen; i++) begin
         word_masked[8*i +: 8] = (PB'(i) < len_ff) ? word_ff[8*i +: 8] : 8'd0;
      end
   end

   kwlex_match #(.KeywordMaxLen(BufLen), .LenBits(PB)) u_match (
      .word(word_masked), .word_len(len_ff), .too_long(long_ff), .kind(word_kind));

   always_comb begin
      logic [7:0] b;
      logic ident_ch, idle, adv;
      int n;
      b = source_byte;
      mode_in = mode_ff; line_in = line_ff; col_in = col_ff;
      sline_in = sline_ff; scol_in = scol_ff; len_in = len_ff;
      long_in = long_ff; word_in = word_ff;
      tok_kind = '0; tok_line = '0; tok_col = '0; tok_len = '0;
      n = 0;
      idle = 1'b0;
      adv = 1'b0;
      ident_ch = is_alpha(b) || is_digit(b) || b == "_";
      if (byte_present) begin
         adv = 1'b1;
         unique case (mode_ff)
            M_COMMENT: idle = (b == "\n");
            M_IDENT: begin
               if (ident_ch) begin
                  for (int i = 0; i < BufLen; i++) begin
                     if (i < KeywordMaxLen && PB'(i) == len_ff) word_in[8*i +: 8] = b;
                  end
                  if (len_ff >= PB'(KeywordMaxLen)) long_in = 1'b1;
                  len_in = sat(len_ff);
               end else begin
                  tok_kind[0 +: 7] = word_kind; tok_line[0 +: PB] = sline_ff;
                  tok_col[0 +: PB] = scol_ff; tok_len[0 +: PB] = len_ff;
                  n = 1; idle = 1'b1;
               end
            end
            M_NUMBER: begin
               if (is_digit(b) || b == ".") len_in = sat(len_ff);
               else begin
                  tok_kind[0 +: 7] = K_NUMBER; tok_line[0 +: PB] = sline_ff;
                  tok_col[0 +: PB] = scol_ff; tok_len[0 +: PB] = len_ff;
                  n = 1; idle = 1'b1;
               end
            end
            M_STRING: begin
               if (b == "\"") begin
                  tok_kind[0 +: 7] = K_STRING; tok_line[0 +: PB] = sline_ff;
                  tok_col[0 +: PB] = scol_ff; tok_len[0 +: PB] = len_ff;
                  n = 1; mode_in = M_IDLE;
               end else len_in = sat(len_ff);
            end
            M_Q1, M_Q2: begin
               if (b == "?" && mode_ff == M_Q1) mode_in = M_Q2;
               else if (b == "?") begin
                  tok_kind[0 +: 7] = K_HOLE; tok_line[0 +: PB] = sline_ff;
                  tok_col[0 +: PB] = scol_ff; tok_len[0 +: PB] = PB'(3);
                  n = 1; mode_in = M_IDLE;
               end else begin
                  tok_kind[0 +: 7] = K_UNKNOWN; tok_line[0 +: PB] = sline_ff;
                  tok_col[0 +: PB] = scol_ff; tok_len[0 +: PB] = One;
                  n = 1; idle = 1'b1;
               end
            end
            default: idle = 1'b1;
         endcase
         if (idle) begin
            mode_in = M_IDLE;
            if (b == " " || b == "\r" || b == "\t") begin
            end else if (b == "#") mode_in = M_COMMENT;
            else if (b == "\n") begin
               tok_kind[7*n +: 7] = K_NEWLINE; tok_line[PB*n +: PB] = line_ff;
               tok_col[PB*n +: PB] = col_ff; tok_len[PB*n +: PB] = PB'(2);
               n = n + 1;
            end else if (is_alpha(b) || b == "_" || is_digit(b) || b == "\"" || b == "?")
            begin
               sline_in = line_ff; scol_in = col_ff; len_in = One;
               if (is_digit(b)) mode_in = M_NUMBER;
               else if (b == "\"") begin mode_in = M_STRING; len_in = '0; end
               else if (b == "?") mode_in = M_Q1;
               else begin
                  mode_in = M_IDENT; long_in = 1'b0;
                  word_in[7:0] = b;
               end
            end else begin
               tok_kind[7*n +: 7] = K_UNKNOWN;
               unique case (b)
                  "[": tok_kind[7*n +: 7] = K_PUNCT0;
                  "]": tok_kind[7*n +: 7] = K_PUNCT0 + 7'd1;
                  "{": tok_kind[7*n +: 7] = K_PUNCT0 + 7'd2;
                  "}": tok_kind[7*n +: 7] = K_PUNCT0 + 7'd3;
                  "(": tok_kind[7*n +: 7] = K_PUNCT0 + 7'd4;
                  ")": tok_kind[7*n +: 7] = K_PUNCT0 + 7'd5;
                  ":": tok_kind[7*n +: 7] = K_PUNCT0 + 7'd6;
                  ",": tok_kind[7*n +: 7] = K_PUNCT0 + 7'd7;
                  default: ;
               endcase
               tok_line[PB*n +: PB] = line_ff; tok_col[PB*n +: PB] = col_ff;
               tok_len[PB*n +: PB] = One;
               n = n + 1;
            end
         end
         if (adv) begin
            if (b == "\n") begin line_in = sat(line_ff); col_in = One; end
            else col_in = sat(col_ff);
         end
      end
      if (end_of_source) begin
         // flush the open token from the state after this byte
         priority if (mode_in == M_IDENT || mode_in == M_NUMBER || mode_in == M_STRING) begin
            // an identifier takes its kind from the compare on the updated word
            tok_kind[7*n +: 7] = (mode_in == M_NUMBER) ? K_NUMBER :
                                 (mode_in == M_STRING) ? K_UNKNOWN : fkind;
            tok_line[PB*n +: PB] = sline_in; tok_col[PB*n +: PB] = scol_in;
            tok_len[PB*n +: PB] = len_in;
            n = n + 1;
         end else if (mode_in == M_Q1 || mode_in == M_Q2) begin
            tok_kind[7*n +: 7] = K_UNKNOWN; tok_line[PB*n +: PB] = sline_in;
            tok_col[PB*n +: PB] = scol_in; tok_len[PB*n +: PB] = One;
            n = n + 1;
         end else begin
         end
         tok_kind[7*n +: 7] = K_END; tok_line[PB*n +: PB] = line_in;
         tok_col[PB*n +: PB] = col_in; tok_len[PB*n +: PB] = '0;
         n = n + 1;
         mode_in = M_IDLE; line_in = One; col_in = One; sline_in = One;
         scol_in = One; len_in = '0; long_in = 1'b0;
      end
      tok_count = 2'(n);
   end

   always_comb begin
      flen = len_ff; flong = long_ff;
      if (byte_present) begin
         if (mode_ff == M_IDENT && (is_alpha(source_byte) || is_digit(source_byte)
             || source_byte == "_")) begin
            flen = sat(len_ff);
            flong = long_ff || (len_ff >= PB'(KeywordMaxLen));
         end else if (mode_ff == M_IDENT || mode_ff == M_IDLE || mode_ff == M_COMMENT
                      || mode_ff == M_NUMBER || mode_ff == M_Q1 || mode_ff == M_Q2) begin
            flen = One; flong = 1'b0;
         end else begin
         end
      end
      for (int i = 0; i < BufLen; i++) begin
         fword[8*i +: 8] = (PB'(i) < flen) ? word_in[8*i +: 8] : 8'd0;
      end
   end

   kwlex_match #(.KeywordMaxLen(BufLen), .LenBits(PB)) u_fmatch (
      .word(fword), .word_len(flen), .too_long(flong), .kind(fkind));

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE; line_ff <= One; col_ff <= One;
         sline_ff <= One; scol_ff <= One; len_ff <= '0; long_ff <= 1'b0;
      end else if (step) begin
         mode_ff <= mode_in; line_ff <= line_in; col_ff <= col_in;
         sline_ff <= sline_in; scol_ff <= scol_in; len_ff <= len_in; long_ff <= long_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) word_ff <= word_in;
   end
endmodule

// File: rtl/core/keyword_lexer.sv
// Top level of the keyword lexer: scanner and token queue.
// Depends on kwlex_pkg and kwlex_scan.
//
//  channel  direction  handshake              payload
//  req_     in         req_valid/req_ready    source_byte, byte_present, end_of_source
//  rsp_     out        rsp_valid/rsp_ready    token_kind, start_line, start_column,
//                                             text_length, last_of_run
//
// A byte is scanned combinationally and yields zero to three tokens, which go
// into a four-entry queue; tokens leave it one per cycle while rsp_ready is high.
// Input is taken whenever the queue has room for three more tokens, so a stream
// of bytes that each make at most one token runs at one per cycle while rsp_ready is high.
// Reset (synchronous) returns the scanner to line 1, column 1 and empties the queue.
module keyword_lexer #(
   parameter int KEYWORD_MAX_LEN = 9,
   parameter int POSITION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_source_byte,
   input  logic                     req_byte_present,
   input  logic                     req_end_of_source,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [6:0]               rsp_token_kind,
   output logic [POSITION_BITS-1:0] rsp_start_line,
   output logic [POSITION_BITS-1:0] rsp_start_column,
   output logic [POSITION_BITS-1:0] rsp_text_length,
   output logic                     rsp_last_of_run
);
   import kwlex_pkg::*;
   localparam int PB = POSITION_BITS;
   localparam int EW = 7 + 3*PB + 1;

   logic                 step;
   logic [1:0]           cnt;
   logic [3*7-1:0]       kinds;
   logic [3*PB-1:0]      lines, cols, lens;

   kwlex_scan #(.KeywordMaxLen(KEYWORD_MAX_LEN), .PositionBits(PB)) u_scan (
      .clock, .reset, .step,
      .source_byte(req_source_byte), .byte_present(req_byte_present),
      .end_of_source(req_end_of_source),
      .tok_count(cnt), .tok_kind(kinds), .tok_line(lines), .tok_col(cols), .tok_len(lens));

   logic [EW-1:0] q_ff [4];
   logic [1:0]    rd_ff, wr_ff;
   logic [2:0]    fill_ff;
   logic          pop;

   assign req_ready = (fill_ff <= 3'd1) || (fill_ff == 3'd2 && pop);
   assign step = req_valid && req_ready;
   assign rsp_valid = fill_ff != 3'd0;
   assign pop = rsp_valid && rsp_ready;
   assign {rsp_token_kind, rsp_start_line, rsp_start_column, rsp_text_length,
           rsp_last_of_run} = q_ff[rd_ff];

   logic [2:0] push;
   assign push = step ? {1'b0, cnt} : 3'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0; wr_ff <= '0; fill_ff <= '0;
      end else begin
         rd_ff <= rd_ff + 2'(pop);
         wr_ff <= wr_ff + push[1:0];
         fill_ff <= fill_ff + push - 3'(pop);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (step && 2'(i) < cnt) begin
            q_ff[wr_ff + 2'(i)] <= {kinds[7*i +: 7], lines[PB*i +: PB], cols[PB*i +: PB],
                                    lens[PB*i +: PB], 2'(i + 1) == cnt};
         end
      end
   end
endmodule

// File: rtl/core/kwlex_checker.sv
// Port checker for keyword_lexer, bound to the top level.
// Depends on kwlex_pkg and the top level's ports.
module kwlex_checker #(
   parameter int PositionBits = 16
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [6:0] rsp_token_kind,
   input logic [PositionBits-1:0] rsp_text_length,
   input logic rsp_last_of_run
);
   import kwlex_pkg::*;

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("request withdrawn while waiting");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_token_kind))
      else $error("result dropped while stalled");
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == K_END |-> rsp_last_of_run)
      else $error("end token not last of run");
   a_end_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == K_END |-> rsp_text_length == '0)
      else $error("end token with length");
   a_nl_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == K_NEWLINE |-> rsp_text_length == PositionBits'(2))
      else $error("newline token length");
endmodule

bind keyword_lexer kwlex_checker #(.PositionBits(POSITION_BITS)) u_kwlex_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_token_kind, .rsp_text_length, .rsp_last_of_run);
